// ===== rtl/multichannel_pulse_time_aligner_unit_assert.svh =====
// assertion macros for the pulse time aligner
`ifndef MULTICHANNEL_PULSE_TIME_ALIGNER_UNIT_ASSERT_SVH
`define MULTICHANNEL_PULSE_TIME_ALIGNER_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define MPTA_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define MPTA_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== rtl/mpta_pkg.sv =====
// shared types and codes for the pulse time aligner
`default_nettype none
package mpta_pkg;
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DROP    = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_MEMBER  = 3'd3;
    localparam logic [2:0] ST_NONE    = 3'd4;
    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_MAX     = 2'd1;
    localparam logic [1:0] REG_ENABLE  = 2'd2;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
    typedef logic [31:0] count_t;
endpackage
`default_nettype wire

// ===== rtl/mpta_counter.sv =====
// saturating event counter
`default_nettype none
module mpta_counter (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           inc,
    output mpta_pkg::count_t    value
);
    import mpta_pkg::*;
    count_t cnt_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (inc && cnt_reg != CNT_MAX)
        begin
            cnt_reg <= cnt_reg + 32'd1;
        end
    end
    assign value = cnt_reg;
endmodule
`default_nettype wire

// ===== rtl/multichannel_pulse_time_aligner_unit.sv =====
// top level: per-channel pulse queues with time-aligned group fetch
//
// A valid add raises its result strobe after a queue update state, then a
// store write state; an add for an unknown or disabled channel answers
// from the queue update state. A fetch scans the enabled channel heads
// through a single compare unit, each enabled channel taking a memory read,
// then a min/max update; a final state closes the pass and tests the
// spread, and the pass is repeated once per head dropped. An empty enabled
// queue or no enabled channel ends the fetch with a no-group result. The
// group is then emitted member by member, a memory read, then a strobe for
// each. busy is high for the whole operation; results appear on the strobe
// valid for one cycle each and cannot be held.
`default_nettype none
module multichannel_pulse_time_aligner_unit #(
    parameter int NUM_CHANNELS = 8,
    parameter int QUEUE_DEPTH  = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        action,
    input  wire logic [2:0]  channel,
    input  wire logic [63:0] timestamp,
    input  wire logic [31:0] payload,
    output logic             valid,
    output logic [2:0]       status,
    output logic [2:0]       channel_res,
    output logic [63:0]      timestamp_res,
    output logic [31:0]      payload_res,
    output logic             last,
    output logic [31:0]      discarded_count,
    output logic [31:0]      invalid_count
);
    import mpta_pkg::*;

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int DW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = CW + DW;
    localparam int CWI = CW + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ADD   = 4'd1;
    localparam logic [3:0] S_ADDW  = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_CMP   = 4'd4;
    localparam logic [3:0] S_DEC   = 4'd5;
    localparam logic [3:0] S_EMIT  = 4'd6;
    localparam logic [3:0] S_EMITR = 4'd7;
    localparam logic [3:0] S_NONE  = 4'd8;

    logic [3:0]  state_reg;
    logic [31:0] timeout_reg;
    logic [4:0]  max_reg;
    logic [7:0]  enable_reg;

    logic [95:0] mem [0:NUM_CHANNELS*QUEUE_DEPTH-1];
    logic [95:0] rd_reg;
    logic [DW-1:0] head_reg [NUM_CHANNELS];
    logic [FW-1:0] fill_reg [NUM_CHANNELS];

    logic [CW-1:0] ch_reg;
    logic        ch_ok_reg;
    logic [63:0] ts_reg;
    logic [31:0] pl_reg;
    logic [CWI-1:0] idx_reg;
    logic        first_reg;
    logic [63:0] lo_reg;
    logic [63:0] hi_reg;
    logic [CW-1:0] lo_ch_reg;
    logic [CW-1:0] rd_ch_reg;

    logic        inc_drop;
    logic        inc_inv;
    logic        add_bad;

    // result register
    logic        valid_reg;
    logic [2:0]  status_reg;
    logic [2:0]  chres_reg;
    logic [63:0] tsres_reg;
    logic [31:0] plres_reg;
    logic        last_reg;

    function automatic logic en(input logic [7:0] e, input int c);
        return (c < 8) ? e[c] : 1'b0;
    endfunction

    logic [FW-1:0] lim;
    always_comb
    begin
        if (max_reg == 5'd0)
            lim = FW'(1);
        else if (32'(max_reg) > 32'(QUEUE_DEPTH))
            lim = FW'(QUEUE_DEPTH);
        else
            lim = FW'(max_reg);
    end

    logic any_en;
    always_comb
    begin
        any_en = 1'b0;
        for (int c = 0; c < NUM_CHANNELS; c++)
            if (en(enable_reg, c))
                any_en = 1'b1;
    end

    // next enabled channel at or after idx
    logic [CWI-1:0] nxt;
    logic           nxt_found;
    always_comb
    begin
        nxt = CWI'(NUM_CHANNELS);
        nxt_found = 1'b0;
        for (int c = NUM_CHANNELS - 1; c >= 0; c--)
            if (CWI'(c) >= idx_reg && en(enable_reg, c))
            begin
                nxt = CWI'(c);
                nxt_found = 1'b1;
            end
    end
    logic [CW-1:0] nch;
    assign nch = nxt[CW-1:0];

    function automatic logic [AW-1:0] addr(input logic [CW-1:0] c, input logic [DW-1:0] h);
        return AW'(c) * AW'(QUEUE_DEPTH) + AW'(h);
    endfunction

    function automatic logic [DW-1:0] wrap(input logic [DW-1:0] h, input logic [FW-1:0] f);
        logic [FW:0] s;
        s = (FW+1)'(h) + (FW+1)'(f);
        if (s >= (FW+1)'(QUEUE_DEPTH))
            s = s - (FW+1)'(QUEUE_DEPTH);
        return DW'(s);
    endfunction

    function automatic logic [DW-1:0] inc_h(input logic [DW-1:0] h);
        return (32'(h) == QUEUE_DEPTH - 1) ? '0 : h + DW'(1);
    endfunction

    logic        we;
    logic [AW-1:0] waddr;
    logic        re;
    logic [AW-1:0] raddr;
    logic [63:0] rts;
    assign rts = rd_reg[95:32];

    logic [63:0] spread;
    assign spread = hi_reg - lo_reg;

    // pulse for a channel outside the block or not enabled
    assign add_bad = !ch_ok_reg || !en(enable_reg, 32'(ch_reg));

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= {ts_reg, pl_reg};
        if (re)
            rd_reg <= mem[raddr];
    end

    always_comb
    begin
        we = (state_reg == S_ADDW);
        waddr = addr(ch_reg, wrap(head_reg[ch_reg], fill_reg[ch_reg]));
        re = 1'b0;
        raddr = addr(nch, head_reg[nch]);
        if ((state_reg == S_SCAN || state_reg == S_EMIT) && nxt_found)
            re = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            timeout_reg <= '0;
            max_reg <= 5'd16;
            enable_reg <= '0;
            valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                head_reg[c] <= '0;
                fill_reg[c] <= '0;
            end
        end
        else
        begin
            valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TIMEOUT: timeout_reg <= cfg_data;
                    REG_MAX:     max_reg <= cfg_data[4:0];
                    REG_ENABLE:  enable_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= action ? (any_en ? S_SCAN : S_NONE) : S_ADD;
                        idx_reg <= '0;
                        first_reg <= 1'b1;
                    end
                end
                S_ADD:
                begin
                    if (add_bad)
                    begin
                        valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        if (fill_reg[ch_reg] >= lim)
                        begin
                            head_reg[ch_reg] <= inc_h(head_reg[ch_reg]);
                            fill_reg[ch_reg] <= fill_reg[ch_reg] - FW'(1);
                        end
                        state_reg <= S_ADDW;
                    end
                end
                S_ADDW:
                begin
                    fill_reg[ch_reg] <= fill_reg[ch_reg] + FW'(1);
                    valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_SCAN:
                begin
                    if (nxt_found)
                    begin
                        if (fill_reg[nch] == '0)
                            state_reg <= S_NONE;
                        else
                        begin
                            rd_ch_reg <= nch;
                            idx_reg <= nxt + CWI'(1);
                            state_reg <= S_CMP;
                        end
                    end
                    else
                        state_reg <= S_DEC;
                end
                S_CMP:
                begin
                    // one compare per channel head against running min and max
                    if (first_reg || rts < lo_reg)
                    begin
                        lo_reg <= rts;
                        lo_ch_reg <= rd_ch_reg;
                    end
                    if (first_reg || rts > hi_reg)
                        hi_reg <= rts;
                    first_reg <= 1'b0;
                    state_reg <= S_SCAN;
                end
                S_DEC:
                begin
                    idx_reg <= '0;
                    first_reg <= 1'b1;
                    if (spread > 64'(timeout_reg))
                    begin
                        head_reg[lo_ch_reg] <= inc_h(head_reg[lo_ch_reg]);
                        fill_reg[lo_ch_reg] <= fill_reg[lo_ch_reg] - FW'(1);
                        state_reg <= S_SCAN;
                    end
                    else
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (nxt_found)
                    begin
                        rd_ch_reg <= nch;
                        head_reg[nch] <= inc_h(head_reg[nch]);
                        fill_reg[nch] <= fill_reg[nch] - FW'(1);
                        idx_reg <= nxt + CWI'(1);
                        state_reg <= S_EMITR;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_EMITR:
                begin
                    valid_reg <= 1'b1;
                    state_reg <= S_EMIT;
                end
                S_NONE:
                begin
                    valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // lookahead: is another enabled channel after the one being emitted
    logic more;
    always_comb
    begin
        more = 1'b0;
        for (int c = 0; c < NUM_CHANNELS; c++)
            if (CWI'(c) >= idx_reg && en(enable_reg, c))
                more = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            ch_reg <= CW'(channel);
            ch_ok_reg <= (32'(channel) < NUM_CHANNELS);
            ts_reg <= timestamp;
            pl_reg <= payload;
        end
        status_reg <= ST_NONE;
        chres_reg <= '0;
        tsres_reg <= '0;
        plres_reg <= '0;
        last_reg <= 1'b1;
        unique case (state_reg)
            S_ADD:
                if (add_bad)
                    status_reg <= ST_INVALID;
                else
                    status_reg <= (fill_reg[ch_reg] >= lim) ? ST_DROP : ST_OK;
            S_ADDW:
                status_reg <= status_reg;
            S_EMITR:
            begin
                status_reg <= ST_MEMBER;
                chres_reg <= 3'(rd_ch_reg);
                tsres_reg <= rd_reg[95:32];
                plres_reg <= rd_reg[31:0];
                last_reg <= !more;
            end
            default: ;
        endcase
    end

    // mpta_counter inc signals
    assign inc_inv = (state_reg == S_ADD) && add_bad;
    assign inc_drop = ((state_reg == S_ADD) && !inc_inv && fill_reg[ch_reg] >= lim)
        || ((state_reg == S_DEC) && spread > 64'(timeout_reg));

    count_t drop_cnt;
    count_t inv_cnt;
    mpta_counter u_drop (.clk(clk), .rst_n(rst_n), .inc(inc_drop), .value(drop_cnt));
    mpta_counter u_inv  (.clk(clk), .rst_n(rst_n), .inc(inc_inv),  .value(inv_cnt));

    assign busy = (state_reg != S_IDLE);
    assign valid = valid_reg;
    assign status = status_reg;
    assign channel_res = chres_reg;
    assign timestamp_res = tsres_reg;
    assign payload_res = plres_reg;
    assign last = last_reg;
    assign discarded_count = drop_cnt;
    assign invalid_count = inv_cnt;
endmodule
`default_nettype wire

// ===== rtl/mpta_checker.sv =====
// port-level checks for the pulse time aligner
`default_nettype none
`include "multichannel_pulse_time_aligner_unit_assert.svh"
module mpta_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        valid,
    input wire logic [2:0]  status,
    input wire logic        last,
    input wire logic [31:0] discarded_count,
    input wire logic [31:0] invalid_count
);
    import mpta_pkg::*;
    `MPTA_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "busy not raised after start")
    `MPTA_ASSERT_IMP(a_status_range, clk, rst_n, valid, status <= ST_NONE, "status code out of range")
    `MPTA_ASSERT_IMP(a_last_single, clk, rst_n, valid && status != ST_MEMBER, last, "single result without last")
    `MPTA_ASSERT_NEXT(a_inv_mono, clk, rst_n, 1'b1, invalid_count >= $past(invalid_count), "invalid count went down")
    `MPTA_ASSERT_NEXT(a_disc_mono, clk, rst_n, 1'b1, discarded_count >= $past(discarded_count), "discard count went down")
endmodule

bind multichannel_pulse_time_aligner_unit mpta_checker u_mpta_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .valid(valid),
    .status(status), .last(last), .discarded_count(discarded_count),
    .invalid_count(invalid_count)
);
`default_nettype wire
